>>> rtl/s8zd_pkg.sv
// Shared types, selector tables and helper functions for the simple-8b zigzag-delta decoder.
package s8zd_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned HDR_W    = 4;
  localparam int unsigned FIELDS_W = WORD_W - HDR_W;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned REP_W    = 8;
  localparam int unsigned BITS_W   = 6;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned EW_W     = 2;

  localparam logic [COUNT_W-1:0] MAX_BLOCK_ELEMENTS = 16'd65535;

  localparam logic [EW_W-1:0] EW_64 = 2'd0;
  localparam logic [EW_W-1:0] EW_32 = 2'd1;
  localparam logic [EW_W-1:0] EW_16 = 2'd2;
  localparam logic [EW_W-1:0] EW_8  = 2'd3;

  typedef struct packed {
    logic load;  // capture a new word
    logic emit;  // produce one result into the output register
  } cmd_t;

  typedef struct packed {
    logic left_zero;  // no elements left in the block
    logic last_res;   // the next result ends this word
    logic slot_free;  // output register can take a result
  } status_t;

  // Field width per selector.
  function automatic logic [BITS_W-1:0] sel_bits(input logic [3:0] sel);
    logic [BITS_W-1:0] b;
    case (sel)
      4'd0:    b = 6'd0;
      4'd1:    b = 6'd0;
      4'd2:    b = 6'd1;
      4'd3:    b = 6'd2;
      4'd4:    b = 6'd3;
      4'd5:    b = 6'd4;
      4'd6:    b = 6'd5;
      4'd7:    b = 6'd6;
      4'd8:    b = 6'd7;
      4'd9:    b = 6'd8;
      4'd10:   b = 6'd10;
      4'd11:   b = 6'd12;
      4'd12:   b = 6'd15;
      4'd13:   b = 6'd20;
      4'd14:   b = 6'd30;
      default: b = 6'd60;
    endcase
    return b;
  endfunction

  // Field count per selector.
  function automatic logic [REP_W-1:0] sel_count(input logic [3:0] sel);
    logic [REP_W-1:0] n;
    case (sel)
      4'd0:    n = 8'd240;
      4'd1:    n = 8'd120;
      4'd2:    n = 8'd60;
      4'd3:    n = 8'd30;
      4'd4:    n = 8'd20;
      4'd5:    n = 8'd15;
      4'd6:    n = 8'd12;
      4'd7:    n = 8'd10;
      4'd8:    n = 8'd8;
      4'd9:    n = 8'd7;
      4'd10:   n = 8'd6;
      4'd11:   n = 8'd5;
      4'd12:   n = 8'd4;
      4'd13:   n = 8'd3;
      4'd14:   n = 8'd2;
      default: n = 8'd1;
    endcase
    return n;
  endfunction

  // Truncate to the configured width, then sign-extend.
  function automatic logic [WORD_W-1:0] fit_width(input logic [EW_W-1:0] ew,
                                                  input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] r;
    case (ew)
      EW_32:   r = {{32{x[31]}}, x[31:0]};
      EW_16:   r = {{48{x[15]}}, x[15:0]};
      EW_8:    r = {{56{x[7]}}, x[7:0]};
      default: r = x;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/s8zd_ctrl.sv
// Controller state machine: sequences word capture and per-field result emission.
module s8zd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  s8zd_pkg::status_t status_i,
  output s8zd_pkg::cmd_t    cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.emit  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // exhausted or empty block: word yields nothing
        if (status_i.left_zero) begin
          state_d = ST_IDLE;
        end else if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.last_res) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/s8zd_datapath.sv
// Datapath: word shifter, zigzag delta accumulator, element counter and output register.
module s8zd_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  s8zd_pkg::cmd_t                     cmd_i,
  output s8zd_pkg::status_t                  status_o,
  input  logic                               cfg_we_i,
  input  logic [s8zd_pkg::EW_W-1:0]          cfg_data_i,
  input  logic [s8zd_pkg::WORD_W-1:0]        packed_word_i,
  input  logic                               block_start_i,
  input  logic [s8zd_pkg::COUNT_W-1:0]       block_count_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [s8zd_pkg::WORD_W-1:0] value_o,
  output logic [s8zd_pkg::REP_W-1:0]         repeat_res_o,
  output logic                               last_o,
  output logic                               block_done_o
);

  logic [s8zd_pkg::EW_W-1:0]     ew_q;
  logic [s8zd_pkg::FIELDS_W-1:0] shreg_q, shreg_d;
  logic [3:0]                    sel_q;
  logic [s8zd_pkg::IDX_W-1:0]    cnt_q, cnt_d;
  logic [s8zd_pkg::WORD_W-1:0]   prev_q, prev_d;
  logic [s8zd_pkg::COUNT_W-1:0]  left_q, left_d;
  logic                          out_valid_q;
  logic [s8zd_pkg::WORD_W-1:0]   value_q;
  logic [s8zd_pkg::REP_W-1:0]    rep_q;
  logic                          last_q, done_q;

  logic [s8zd_pkg::BITS_W-1:0]   bits;
  logic [s8zd_pkg::REP_W-1:0]    nfields, rep;
  logic                          is_run, last_field, last_res;
  logic [s8zd_pkg::FIELDS_W-1:0] mask, z;
  logic [s8zd_pkg::WORD_W-1:0]   delta, sum;
  logic [s8zd_pkg::COUNT_W-1:0]  cnt_c;

  assign bits    = s8zd_pkg::sel_bits(sel_q);
  assign nfields = s8zd_pkg::sel_count(sel_q);
  assign is_run  = (bits == '0);

  // run length limited to what the block still needs
  assign rep = (s8zd_pkg::COUNT_W'(nfields) < left_q) ? nfields : left_q[s8zd_pkg::REP_W-1:0];

  assign mask  = (s8zd_pkg::FIELDS_W'(1) << bits) - s8zd_pkg::FIELDS_W'(1);
  assign z     = shreg_q & mask;
  assign delta = {{(s8zd_pkg::WORD_W - s8zd_pkg::FIELDS_W + 1){1'b0}},
                  z[s8zd_pkg::FIELDS_W-1:1]} ^ {s8zd_pkg::WORD_W{z[0]}};
  assign sum   = prev_q + delta;

  assign last_field = ((s8zd_pkg::REP_W'(cnt_q) + s8zd_pkg::REP_W'(1)) == nfields)
                      || (left_q == s8zd_pkg::COUNT_W'(1));
  assign last_res   = is_run || last_field;
  assign cnt_c      = is_run ? s8zd_pkg::COUNT_W'(rep) : s8zd_pkg::COUNT_W'(1);

  assign status_o.left_zero = (left_q == '0);
  assign status_o.last_res  = last_res;
  assign status_o.slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    shreg_d = shreg_q;
    cnt_d   = cnt_q;
    prev_d  = prev_q;
    left_d  = left_q;
    if (cmd_i.load) begin
      shreg_d = packed_word_i[s8zd_pkg::WORD_W-1:s8zd_pkg::HDR_W];
      cnt_d   = '0;
      if (block_start_i) begin
        prev_d = '0;
        left_d = (block_count_i > s8zd_pkg::MAX_BLOCK_ELEMENTS) ?
                 s8zd_pkg::MAX_BLOCK_ELEMENTS : block_count_i;
      end
    end else if (cmd_i.emit) begin
      left_d = left_q - cnt_c;
      if (!is_run) begin
        shreg_d = shreg_q >> bits;
        cnt_d   = cnt_q + s8zd_pkg::IDX_W'(1);
        prev_d  = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ew_q        <= s8zd_pkg::EW_64;
      prev_q      <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ew_q <= cfg_data_i;
      end
      prev_q <= prev_d;
      left_q <= left_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    cnt_q   <= cnt_d;
    if (cmd_i.load) begin
      sel_q <= packed_word_i[s8zd_pkg::HDR_W-1:0];
    end
    if (cmd_i.emit) begin
      value_q <= s8zd_pkg::fit_width(ew_q, prev_d);
      rep_q   <= is_run ? rep : s8zd_pkg::REP_W'(1);
      last_q  <= last_res;
      done_q  <= (left_d == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign repeat_res_o = rep_q;
  assign last_o       = last_q;
  assign block_done_o = done_q;

endmodule

>>> rtl/simple8b_zigzag_delta_int_decoder.sv
// Top level of the simple-8b zigzag-delta integer decoder.
// Words are accepted only in idle; each field result is then registered in the emit
// state, up to 60 per word, by the single shared field adder stepping one field per
// cycle while the output is free; a run selector yields one result. Output stalls hold
// the sequencer. Reset is asynchronous, active low, and clears the running value, the
// element count and the width register to 64-bit mode.
module simple8b_zigzag_delta_int_decoder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [s8zd_pkg::EW_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [s8zd_pkg::WORD_W-1:0]        packed_word_i,
  input  logic                               block_start_i,
  input  logic [s8zd_pkg::COUNT_W-1:0]       block_count_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [s8zd_pkg::WORD_W-1:0] value_o,
  output logic [s8zd_pkg::REP_W-1:0]         repeat_res_o,
  output logic                               last_o,
  output logic                               block_done_o
);

  s8zd_pkg::cmd_t    cmd;
  s8zd_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  s8zd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  s8zd_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .packed_word_i (packed_word_i),
    .block_start_i (block_start_i),
    .block_count_i (block_count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .repeat_res_o  (repeat_res_o),
    .last_o        (last_o),
    .block_done_o  (block_done_o)
  );

endmodule
